>>> design/http_message_framer_defines.svh
// assertion macros for the http message framer
// no dependencies; included by the top level only
`ifndef HTTP_MESSAGE_FRAMER_DEFINES_SVH
`define HTTP_MESSAGE_FRAMER_DEFINES_SVH

// condition on this edge implies consequence on this edge
`define HMF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("http message framer: same-cycle check failed");

// condition on this edge implies consequence on the next edge
`define HMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("http message framer: next-cycle check failed");

`endif

>>> design/hmf_pkg.sv
// shared types and constants for the http message framer
// no dependencies; used by hmf_value_parse, hmf_core and the top level
package hmf_pkg;

  localparam int FIELD_LEN = 16;
  localparam int TERM_LEN  = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_C = 8'h43;

  // "Content-Length: "
  localparam logic [7:0] FIELD_PAT [FIELD_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
  };

  localparam logic [7:0] TERM_PAT [TERM_LEN] = '{CH_CR, CH_LF, CH_CR, CH_LF};

  localparam logic [3:0] FIELD_LAST = 4'(FIELD_LEN - 1);
  localparam logic [1:0] TERM_LAST  = 2'(TERM_LEN - 1);

  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_DIGITS = 2'd1,
    MODE_DONE   = 2'd2
  } value_mode_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        in_body;
    logic        is_last;
    logic [15:0] header_length;
    logic [30:0] body_length;
    logic        length_saturated;
  } hmf_result_t;

endpackage

>>> design/hmf_value_parse.sv
// content-length value parser: one byte of atoi-style decoding
// depends on hmf_pkg
module hmf_value_parse import hmf_pkg::*; #(
  parameter int BODY_LENGTH_WIDTH = 31
) (
  input  logic [7:0]                   data_byte,
  input  value_mode_t                  mode,
  input  logic [BODY_LENGTH_WIDTH-1:0] value,
  output value_mode_t                  mode_next,
  output logic [BODY_LENGTH_WIDTH-1:0] value_next,
  output logic                         sat_set
);

  localparam int AW = BODY_LENGTH_WIDTH + 4;

  logic                         is_digit;
  logic                         is_blank;
  logic                         take;
  logic [AW-1:0]                prod;
  logic [AW-1:0]                lim_ext;
  logic [BODY_LENGTH_WIDTH-1:0] lim;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                    (data_byte == CH_VT) || (data_byte == CH_FF);
  assign lim      = '1;
  assign lim_ext  = AW'(lim);
  // value * 10 + digit, low nibble of an ascii digit is its value
  assign prod = (AW'(value) << 3) + (AW'(value) << 1) + AW'(data_byte[3:0]);

  always_comb begin
    mode_next  = mode;
    value_next = value;
    sat_set    = 1'b0;
    take       = 1'b0;
    unique case (mode)
      MODE_SKIP: begin
        if (is_blank) begin
          mode_next = mode;
        end else if (data_byte == CH_PLUS) begin
          mode_next = MODE_DIGITS;
        end else if (!is_digit) begin
          mode_next = MODE_DONE;
        end else begin
          take = 1'b1;
        end
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          take = 1'b1;
        end else begin
          mode_next = MODE_DONE;
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
    if (take) begin
      mode_next = MODE_DIGITS;
      if (prod > lim_ext) begin
        value_next = lim;
        sat_set    = 1'b1;
      end else begin
        value_next = prod[BODY_LENGTH_WIDTH-1:0];
      end
    end
  end

endmodule

>>> design/hmf_core.sv
// framing state and per-beat update: terminator and field matching,
// header counting and body countdown; depends on hmf_pkg and hmf_value_parse
module hmf_core import hmf_pkg::*; #(
  parameter int HEADER_COUNT_WIDTH = 16,
  parameter int BODY_LENGTH_WIDTH  = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  output hmf_result_t result
);

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  localparam logic [HEADER_COUNT_WIDTH-1:0] HC_MAX = '1;

  phase_t                        phase, phase_next;
  logic [1:0]                    term_match, term_match_next;
  logic [3:0]                    field_match, field_match_next;
  logic                          field_found, field_found_next;
  value_mode_t                   value_mode, value_mode_next;
  logic [BODY_LENGTH_WIDTH-1:0]  length_value, length_value_next;
  logic [BODY_LENGTH_WIDTH-1:0]  body_remaining, body_remaining_next;
  logic [HEADER_COUNT_WIDTH-1:0] header_count, header_count_next;
  logic                          saturated, saturated_next;

  value_mode_t                   pv_mode;
  logic [BODY_LENGTH_WIDTH-1:0]  pv_value;
  logic                          pv_sat;
  logic [HEADER_COUNT_WIDTH-1:0] hc_inc;
  logic [BODY_LENGTH_WIDTH-1:0]  rem_dec;
  logic                          term_done;
  logic [HEADER_COUNT_WIDTH-1:0] hlen_sel;
  logic [BODY_LENGTH_WIDTH-1:0]  blen_sel;
  logic [HEADER_COUNT_WIDTH+15:0] hlen_ext;
  logic [BODY_LENGTH_WIDTH+30:0]  blen_ext;

  hmf_value_parse #(
    .BODY_LENGTH_WIDTH(BODY_LENGTH_WIDTH)
  ) u_value_parse (
    .data_byte (data_byte),
    .mode      (value_mode),
    .value     (length_value),
    .mode_next (pv_mode),
    .value_next(pv_value),
    .sat_set   (pv_sat)
  );

  assign hc_inc  = (header_count != HC_MAX) ? header_count + 1'b1 : header_count;
  assign rem_dec = (body_remaining != '0) ? body_remaining - 1'b1 : body_remaining;

  always_comb begin
    phase_next          = phase;
    term_match_next     = term_match;
    field_match_next    = field_match;
    field_found_next    = field_found;
    value_mode_next     = value_mode;
    length_value_next   = length_value;
    body_remaining_next = body_remaining;
    header_count_next   = header_count;
    saturated_next      = saturated;
    term_done           = 1'b0;
    hlen_sel            = '0;
    blen_sel            = '0;
    result.in_body      = 1'b0;
    result.is_last      = 1'b0;

    if (phase == PH_BODY) begin
      result.in_body      = 1'b1;
      body_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        result.is_last = 1'b1;
        hlen_sel       = header_count;
        blen_sel       = length_value;
      end
    end else begin
      header_count_next = hc_inc;
      if (hc_inc == HC_MAX) begin
        saturated_next = 1'b1;
      end

      if (field_found) begin
        value_mode_next   = pv_mode;
        length_value_next = pv_value;
        if (pv_sat) begin
          saturated_next = 1'b1;
        end
      end else if (data_byte == FIELD_PAT[field_match]) begin
        if (field_match == FIELD_LAST) begin
          field_found_next = 1'b1;
          value_mode_next  = MODE_SKIP;
        end else begin
          field_match_next = field_match + 1'b1;
        end
      end else begin
        // a 'C' can open a fresh match
        field_match_next = (data_byte == CH_UPPER_C) ? 4'd1 : 4'd0;
      end

      if (data_byte == TERM_PAT[term_match]) begin
        if (term_match == TERM_LAST) begin
          term_done       = 1'b1;
          term_match_next = 2'd0;
        end else begin
          term_match_next = term_match + 1'b1;
        end
      end else begin
        term_match_next = (data_byte == CH_CR) ? 2'd1 : 2'd0;
      end

      if (term_done) begin
        if (length_value_next == '0) begin
          result.is_last = 1'b1;
          hlen_sel       = hc_inc;
        end else begin
          phase_next          = PH_BODY;
          body_remaining_next = length_value_next;
        end
      end
    end

    hlen_ext                = {16'd0, hlen_sel};
    blen_ext                = {31'd0, blen_sel};
    result.out_byte         = data_byte;
    result.header_length    = hlen_ext[15:0];
    result.body_length      = blen_ext[30:0];
    result.length_saturated = saturated_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && result.is_last)) begin
      phase          <= PH_HEADER;
      term_match     <= 2'd0;
      field_match    <= 4'd0;
      field_found    <= 1'b0;
      value_mode     <= MODE_SKIP;
      length_value   <= '0;
      body_remaining <= '0;
      header_count   <= '0;
      saturated      <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      term_match     <= term_match_next;
      field_match    <= field_match_next;
      field_found    <= field_found_next;
      value_mode     <= value_mode_next;
      length_value   <= length_value_next;
      body_remaining <= body_remaining_next;
      header_count   <= header_count_next;
      saturated      <= saturated_next;
    end
  end

endmodule

>>> design/http_message_framer.sv
// http message framer top level: input register, framing core, result register
// depends on hmf_pkg, hmf_core and http_message_framer_defines.svh
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | data_byte
//   out     | out_valid / out_ready| out_byte, in_body, is_last, header_length,
//           |                      | body_length, length_saturated
//
// one beat in and one beat out per clock when neither side stalls
// a byte passes the input register, then the core update into the result register
// the framing state advances only when a byte moves from the input to the result register
// a stalled output holds the result; the input register still takes one more beat
// rst is synchronous and clears both valids and the framing state
`include "http_message_framer_defines.svh"

module http_message_framer import hmf_pkg::*; #(
  parameter int HEADER_COUNT_WIDTH = 16,
  parameter int BODY_LENGTH_WIDTH  = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        in_body,
  output logic        is_last,
  output logic [15:0] header_length,
  output logic [30:0] body_length,
  output logic        length_saturated
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        advance;
  logic        fire;
  hmf_result_t core_result;

  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  hmf_core #(
    .HEADER_COUNT_WIDTH(HEADER_COUNT_WIDTH),
    .BODY_LENGTH_WIDTH (BODY_LENGTH_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .data_byte(s1_byte),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte         <= core_result.out_byte;
      in_body          <= core_result.in_body;
      is_last          <= core_result.is_last;
      header_length    <= core_result.header_length;
      body_length      <= core_result.body_length;
      length_saturated <= core_result.length_saturated;
    end
  end

  // lengths are only reported on the closing beat
  `HMF_ASSERT_SAME(a_len_only_last, clk, rst, out_valid && !is_last, (header_length == 16'd0) && (body_length == 31'd0))
  // a message closed in the header has no body
  `HMF_ASSERT_SAME(a_hdr_close_no_body, clk, rst, out_valid && is_last && !in_body, body_length == 31'd0)
  // an empty result register never blocks the input
  `HMF_ASSERT_SAME(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  // a byte waiting in the input register moves on once the output drains
  `HMF_ASSERT_NEXT(a_input_drains, clk, rst, s1_valid && !out_valid, out_valid)

endmodule

>>> verif/http_message_framer_test.sv
// self-checking testbench for http_message_framer: byte stream in, framed beats out
// depends on hmf_pkg and the http_message_framer top level
// predicts every output beat from its own copy of the framing state
module http_message_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hmf_pkg::*;

  localparam logic [31:0] HDR_MAX     = 32'h0000_FFFF;
  localparam logic [63:0] LEN_MAX     = 64'h0000_0000_7FFF_FFFF;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        in_body;
  logic        is_last;
  logic [15:0] header_length;
  logic [30:0] body_length;
  logic        length_saturated;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_out = 1'b0;
  int bad_fields = 0;
  int bytes_sent = 0;

  hmf_result_t framed_q[$];
  logic [7:0]  stream_q[$];

  // framing state of the predictor
  logic        body_phase;
  int          term_hits;
  int          name_hits;
  logic        name_seen;
  value_mode_t val_mode;
  logic [63:0] len_value;
  logic [31:0] hdr_count;
  logic [63:0] body_left;
  logic        sat;

  http_message_framer u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .in_body          (in_body),
    .is_last          (is_last),
    .header_length    (header_length),
    .body_length      (body_length),
    .length_saturated (length_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void start_message();
    body_phase  = 1'b0;
    term_hits   = 0;
    name_hits   = 0;
    name_seen   = 1'b0;
    val_mode    = MODE_SKIP;
    len_value   = '0;
    hdr_count   = '0;
    body_left   = '0;
    sat         = 1'b0;
  endfunction

  function automatic hmf_result_t frame_byte(logic [7:0] b);
    hmf_result_t r;
    logic        digit;
    logic        take;
    logic [63:0] acc;
    r = '0;
    take = 1'b0;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    r.out_byte = b;
    if (body_phase) begin
      r.in_body = 1'b1;
      if (body_left != 0) body_left--;
      if (body_left == 0) begin
        r.is_last = 1'b1;
        r.header_length = hdr_count[15:0];
        r.body_length = len_value[30:0];
      end
    end else begin
      if (hdr_count < HDR_MAX) hdr_count++;
      if (hdr_count >= HDR_MAX) sat = 1'b1;
      if (name_seen) begin
        case (val_mode)
          MODE_SKIP: begin
            if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) begin
              // leading blanks
            end else if (b == CH_PLUS) begin
              val_mode = MODE_DIGITS;
            end else if (!digit) begin
              val_mode = MODE_DONE;
            end else begin
              val_mode = MODE_DIGITS;
              take = 1'b1;
            end
          end
          MODE_DIGITS: begin
            if (!digit) val_mode = MODE_DONE;
            else take = 1'b1;
          end
          default: ;
        endcase
        if (take) begin
          acc = len_value * 10 + (b - CH_ZERO);
          if (acc > LEN_MAX) begin
            acc = LEN_MAX;
            sat = 1'b1;
          end
          len_value = acc;
        end
      end else begin
        if (name_hits < FIELD_LEN && b == FIELD_PAT[name_hits]) name_hits++;
        else name_hits = (b == CH_UPPER_C) ? 1 : 0;
        if (name_hits >= FIELD_LEN) begin
          name_seen = 1'b1;
          val_mode = MODE_SKIP;
        end
      end
      if (b == TERM_PAT[term_hits % TERM_LEN]) term_hits++;
      else term_hits = (b == CH_CR) ? 1 : 0;
      if (term_hits >= TERM_LEN) begin
        term_hits = 0;
        if (len_value == 0) begin
          r.is_last = 1'b1;
          r.header_length = hdr_count[15:0];
        end else begin
          body_phase = 1'b1;
          body_left = len_value;
        end
      end
    end
    r.length_saturated = sat;
    if (r.is_last) start_message();
    return r;
  endfunction

  task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      if (bad_fields < 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      bad_fields++;
    end
  endtask

  // check first, then predict: a beat never leaves in the edge it arrives
  always @(posedge clk) begin
    hmf_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (framed_q.size() == 0) begin
          if (bad_fields < 10)
            $display("%0t: output beat 0x%0h with nothing expected", $realtime, out_byte);
          bad_fields++;
        end else begin
          want = framed_q.pop_front();
          note_field("out_byte", 32'(want.out_byte), 32'(out_byte));
          note_field("in_body", 32'(want.in_body), 32'(in_body));
          note_field("is_last", 32'(want.is_last), 32'(is_last));
          note_field("header_length", 32'(want.header_length), 32'(header_length));
          note_field("body_length", 32'(want.body_length), 32'(body_length));
          note_field("length_saturated", 32'(want.length_saturated),
                     32'(length_saturated));
        end
      end
      if (in_valid && in_ready) framed_q.push_back(frame_byte(data_byte));
    end
  end

  always @(posedge clk)
    out_ready <= !hold_out && ($urandom_range(99) >= recv_stall_pct);

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("http_message_framer regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endtask

  task automatic add_crlf();
    stream_q.push_back(CH_CR);
    stream_q.push_back(CH_LF);
  endtask

  task automatic add_body(input int n);
    repeat (n) stream_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  task automatic test_missing_field();
    add_text("GET / HTTP/1.1"); add_crlf();
    add_text("Host: a"); add_crlf(); add_crlf();
    // lower-case name is not the field
    add_text("content-length: 3"); add_crlf(); add_crlf();
    add_text("Content-Length: 0"); add_crlf(); add_crlf();
    send_stream();
  endtask

  task automatic test_body_framing();
    add_text("Content-Length: 5"); add_crlf(); add_crlf();
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    stream_q.push_back(CH_CR);
    stream_q.push_back(CH_LF);
    stream_q.push_back(8'h80);
    add_text("Content-Length: 1"); add_crlf(); add_crlf();
    stream_q.push_back(8'h7F);
    // nul in the header and a stray cr before the terminator
    stream_q.push_back(8'h00);
    stream_q.push_back(CH_CR);
    add_crlf(); add_crlf();
    send_stream();
  endtask

  task automatic test_value_forms();
    add_text("Content-Length: ");
    stream_q.push_back(CH_TAB);
    stream_q.push_back(CH_VT);
    stream_q.push_back(CH_FF);
    add_text(" +002"); add_crlf(); add_crlf();
    add_body(2);
    add_text("Content-Length: -4"); add_crlf(); add_crlf();
    add_text("Content-Length: abc"); add_crlf(); add_crlf();
    // line break while skipping blanks ends the value
    add_text("Content-Length: "); add_crlf();
    add_text("X: 4"); add_crlf(); add_crlf();
    // only the first occurrence counts
    add_text("Content-Length: 2"); add_crlf();
    add_text("Content-Length: 7"); add_crlf(); add_crlf();
    add_body(2);
    // restart of the name match on a capital c
    add_text("Content-LengtContent-Length: 3x"); add_crlf(); add_crlf();
    add_body(3);
    send_stream();
  endtask

  task automatic build_random_message();
    int    pick;
    int    n_hdr;
    int    len_at;
    int    form;
    int    val;
    logic  framed;
    pick = $urandom_range(99);
    if (pick < 10) begin
      add_body($urandom_range(1, 12));
      return;
    end
    case ($urandom_range(3))
      0: add_text("GET /index.html HTTP/1.1");
      1: add_text("POST /upload HTTP/1.1");
      2: add_text("HTTP/1.1 200 OK");
      default: add_text("PUT /a HTTP/1.0");
    endcase
    add_crlf();
    n_hdr = $urandom_range(3);
    len_at = ($urandom_range(99) < 75) ? $urandom_range(n_hdr) : -1;
    val = 0;
    for (int h = 0; h <= n_hdr; h++) begin
      if (h == len_at) begin
        form = $urandom_range(99);
        val = $urandom_range(20);
        if (form < 5) add_text("Content-Length:");
        else add_text("Content-Length: ");
        repeat ($urandom_range(2)) begin
          case ($urandom_range(3))
            0: stream_q.push_back(CH_SPACE);
            1: stream_q.push_back(CH_TAB);
            2: stream_q.push_back(CH_VT);
            default: stream_q.push_back(CH_FF);
          endcase
        end
        if (form >= 80 && form < 88) add_text("+");
        if (form >= 88 && form < 94) add_text("-");
        if (form >= 94) add_text("z");
        if ($urandom_range(4) == 0) add_text("00");
        add_text($sformatf("%0d", val));
        if (form < 5 || form >= 88) val = 0;
        add_crlf();
      end
      if (h < n_hdr) begin
        add_text("X-H: ");
        repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        add_crlf();
      end
    end
    // most messages are well formed; a few lose the blank line
    framed = $urandom_range(99) < 90;
    if (framed) begin
      add_crlf();
      add_body(val);
    end
  endtask

  task automatic test_random_traffic();
    int stop_at;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      stop_at = bytes_sent + 25;
      while (bytes_sent < stop_at) begin
        build_random_message();
        send_stream();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // the receiver holds off long enough for the input side to stall
  task automatic test_output_hold();
    fork
      begin
        @(negedge clk) hold_out = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        @(negedge clk) hold_out = 1'b0;
      end
    join_none
    repeat (2) begin
      build_random_message();
      send_stream();
    end
  endtask

  // leaves the block in an endless body, so it must come last
  task automatic test_length_saturation();
    add_text("Content-Length: 99999999999"); add_crlf(); add_crlf();
    add_body(6);
    send_stream();
  endtask

  initial begin
    start_message();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_missing_field();
    test_body_framing();
    test_value_forms();
    test_random_traffic();
    test_output_hold();
    test_length_saturation();
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bad_fields == 0 && framed_q.size() == 0) begin
      $display("http_message_framer regression: pass");
    end else begin
      $display("http_message_framer regression: fail");
    end
    $finish;
  end

endmodule
